/* src/trapmv_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trapmv_pkg
// Widths, tdata layout and the saturation helper for the trapezoid move
// position pipeline.
// ---------------------------------------------------------------------------
package trapmv_pkg;

	localparam int TIME_W  = 40;   // elapsed time, signed Q16.24
	localparam int PH_W    = 32;   // phase duration, unsigned Q8.24
	localparam int TOT_W   = 34;   // total duration, Q10.24
	localparam int SPD_W   = 32;   // speed, acceleration, ratio
	localparam int POS_W   = 48;   // coordinates and distance, Q32.16
	localparam int PROD_W  = 64;   // 32 x 32 product
	localparam int SUM_W   = 58;   // wide signed sum before saturation

	localparam int IN_W    = 312;  // 39 bytes, fields fill it exactly
	localparam int OUT_W   = 96;   // 12 bytes

	localparam int NUM_STAGES = 12;

	// input tdata bit offsets, lowest field first
	localparam int OFS_ELAPSED = 0;
	localparam int OFS_TA      = OFS_ELAPSED + TIME_W;
	localparam int OFS_TC      = OFS_TA + PH_W;
	localparam int OFS_TD      = OFS_TC + PH_W;
	localparam int OFS_V0      = OFS_TD + PH_W;
	localparam int OFS_VC      = OFS_V0 + SPD_W;
	localparam int OFS_ACC     = OFS_VC + SPD_W;
	localparam int OFS_START   = OFS_ACC + SPD_W;
	localparam int OFS_RATIO   = OFS_START + POS_W;

	// clamp a wide signed value into the 48-bit signed range
	function automatic logic signed [POS_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
		logic hi_any;
		logic hi_all;
		hi_any = |v[SUM_W-2:POS_W-1];
		hi_all = &v[SUM_W-2:POS_W-1];
		if (!v[SUM_W-1] && hi_any) begin
			sat48 = {1'b0, {(POS_W-1){1'b1}}};
		end else if (v[SUM_W-1] && !hi_all) begin
			sat48 = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			sat48 = v[POS_W-1:0];
		end
	endfunction

endpackage

/* src/trapezoid_move_position_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trapezoid_move_position_top
// Samples one axis of a trapezoidal move at a given time: path distance and
// axis coordinate, fixed point, saturated to 48 bits.
// ---------------------------------------------------------------------------
// Twelve-stage pipeline: an item enters every clock unless the pipeline holds,
// and its result moves through every stage into the output register, so
// sustained throughput is one item per cycle. The time clamp, the phase split,
// two rounds of 32x32 multiplies for the phase terms, the sum and saturation,
// and the split 32x24 ratio multiply each take their own register stages. When
// the output item is not taken, the whole pipeline holds; a bubble in the
// output register lets a new item in even while downstream stalls.
module trapezoid_move_position_top
	import trapmv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// elapsed_time[39:0], accel_time[71:40], cruise_time[103:72],
	// decel_time[135:104], start_speed[167:136], cruise_speed[199:168],
	// acceleration[231:200], start_coord[279:232], axis_ratio[311:280]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// axis_coord[47:0], path_distance[95:48]
	output logic [OUT_W-1:0] m_tdata
);

	logic                    adv;
	logic [NUM_STAGES-1:0]   vld_q;

	// input fields
	logic signed [TIME_W-1:0] elapsed_time;
	logic [PH_W-1:0]          accel_time, cruise_time, decel_time;
	logic signed [SPD_W-1:0]  start_speed, cruise_speed, acceleration, axis_ratio;
	logic signed [POS_W-1:0]  start_coord;

	assign elapsed_time = s_tdata[OFS_ELAPSED +: TIME_W];
	assign accel_time   = s_tdata[OFS_TA +: PH_W];
	assign cruise_time  = s_tdata[OFS_TC +: PH_W];
	assign decel_time   = s_tdata[OFS_TD +: PH_W];
	assign start_speed  = s_tdata[OFS_V0 +: SPD_W];
	assign cruise_speed = s_tdata[OFS_VC +: SPD_W];
	assign acceleration = s_tdata[OFS_ACC +: SPD_W];
	assign start_coord  = s_tdata[OFS_START +: POS_W];
	assign axis_ratio   = s_tdata[OFS_RATIO +: SPD_W];

	// advance everything unless a finished item is waiting
	assign adv      = m_tready || !vld_q[NUM_STAGES-1];
	assign s_tready = adv;
	assign m_tvalid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NUM_STAGES-2:0], s_tvalid};
		end
	end

	// ---------------- stage 1: clamp time ----------------
	logic [TOT_W-1:0]         total_c;
	logic [TOT_W-2:0]         tab_c;
	logic [TOT_W-1:0]         t_c;
	logic                     pos_c;

	logic [TOT_W-1:0]         t_s1;
	logic [TOT_W-2:0]         tab_s1;
	logic [PH_W-1:0]          ta_max_s1, tc_max_s1;
	logic signed [SPD_W-1:0]  v0_s1, vc_s1, acc_s1, ratio_s1;
	logic signed [POS_W-1:0]  start_s1;

	always_comb begin
		total_c = {2'b00, accel_time} + {2'b00, cruise_time} + {2'b00, decel_time};
		tab_c   = {1'b0, accel_time} + {1'b0, cruise_time};
		pos_c   = !elapsed_time[TIME_W-1] && (elapsed_time != '0);
		if (!pos_c) begin
			t_c = '0;
		end else if (unsigned'(elapsed_time) > {{(TIME_W-TOT_W){1'b0}}, total_c}) begin
			t_c = total_c;
		end else begin
			t_c = elapsed_time[TOT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1      <= t_c;
			tab_s1    <= tab_c;
			ta_max_s1 <= accel_time;
			tc_max_s1 <= cruise_time;
			v0_s1     <= start_speed;
			vc_s1     <= cruise_speed;
			acc_s1    <= acceleration;
			ratio_s1  <= axis_ratio;
			start_s1  <= start_coord;
		end
	end

	// ---------------- stage 2: split over phases ----------------
	logic [PH_W-1:0]          ta_c, tc_c, td_c;
	logic [TOT_W-1:0]         rem_a_c, rem_ab_c;
	logic [TOT_W-1:0]         split_sum_c;

	logic [PH_W-1:0]          ta_s2, tc_s2, td_s2;
	logic [SPD_W-1:0]         v0m_s2, vcm_s2, accm_s2;
	logic                     v0neg_s2, vcneg_s2, accneg_s2;
	logic signed [SPD_W-1:0]  ratio_s2;
	logic signed [POS_W-1:0]  start_s2;

	always_comb begin
		rem_a_c  = t_s1 - {2'b00, ta_max_s1};
		rem_ab_c = t_s1 - {1'b0, tab_s1};
		ta_c = (t_s1 > {2'b00, ta_max_s1}) ? ta_max_s1 : t_s1[PH_W-1:0];
		if (t_s1 <= {2'b00, ta_max_s1}) begin
			tc_c = '0;
		end else if (rem_a_c > {2'b00, tc_max_s1}) begin
			tc_c = tc_max_s1;
		end else begin
			tc_c = rem_a_c[PH_W-1:0];
		end
		// time never exceeds the total, so the decel part needs no upper clamp
		td_c = (t_s1 > {1'b0, tab_s1}) ? rem_ab_c[PH_W-1:0] : '0;
		split_sum_c = {2'b00, ta_c} + {2'b00, tc_c} + {2'b00, td_c};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s2     <= ta_c;
			tc_s2     <= tc_c;
			td_s2     <= td_c;
			v0neg_s2  <= v0_s1[SPD_W-1];
			vcneg_s2  <= vc_s1[SPD_W-1];
			accneg_s2 <= acc_s1[SPD_W-1];
			v0m_s2    <= v0_s1[SPD_W-1] ? (~v0_s1 + 1'b1) : v0_s1;
			vcm_s2    <= vc_s1[SPD_W-1] ? (~vc_s1 + 1'b1) : vc_s1;
			accm_s2   <= acc_s1[SPD_W-1] ? (~acc_s1 + 1'b1) : acc_s1;
			ratio_s2  <= ratio_s1;
			start_s2  <= start_s1;
		end
	end

	// ---------------- stage 3: speed and square products ----------------
	logic [PROD_W-1:0]        sqa_full_c, sqd_full_c;

	logic [PROD_W-1:0]        pv0_s3, pvc_s3, pvd_s3;
	logic [PH_W-1:0]          sqa_s3, sqd_s3;
	logic [SPD_W-1:0]         accm_s3;
	logic                     v0neg_s3, vcneg_s3, accneg_s3;
	logic signed [SPD_W-1:0]  ratio_s3;
	logic signed [POS_W-1:0]  start_s3;

	assign sqa_full_c = ta_s2 * ta_s2;
	assign sqd_full_c = td_s2 * td_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pv0_s3    <= v0m_s2 * ta_s2;
			pvc_s3    <= vcm_s2 * tc_s2;
			pvd_s3    <= vcm_s2 * td_s2;
			sqa_s3    <= sqa_full_c[PROD_W-1:PH_W];
			sqd_s3    <= sqd_full_c[PROD_W-1:PH_W];
			accm_s3   <= accm_s2;
			v0neg_s3  <= v0neg_s2;
			vcneg_s3  <= vcneg_s2;
			accneg_s3 <= accneg_s2;
			ratio_s3  <= ratio_s2;
			start_s3  <= start_s2;
		end
	end

	// ---------------- stage 4: round speed terms, acceleration products ----
	localparam int SPT_W = 41;   // signed speed term
	localparam int SQT_W = 56;   // signed square term

	logic [PROD_W-1:0]        rv0_c, rvc_c, rvd_c;

	logic signed [SPT_W-1:0]  tv0_s4, tvc_s4, tvd_s4;
	logic [PROD_W-1:0]        pa_s4, pd_s4;
	logic                     accneg_s4;
	logic signed [SPD_W-1:0]  ratio_s4;
	logic signed [POS_W-1:0]  start_s4;

	// round to nearest, ties away from zero, on the magnitude
	assign rv0_c = (pv0_s3 + (PROD_W'(1) << 23)) >> 24;
	assign rvc_c = (pvc_s3 + (PROD_W'(1) << 23)) >> 24;
	assign rvd_c = (pvd_s3 + (PROD_W'(1) << 23)) >> 24;

	always_ff @(posedge clk) begin
		if (adv) begin
			tv0_s4 <= v0neg_s3 ? -$signed({1'b0, rv0_c[SPT_W-2:0]})
			                   :  $signed({1'b0, rv0_c[SPT_W-2:0]});
			tvc_s4 <= vcneg_s3 ? -$signed({1'b0, rvc_c[SPT_W-2:0]})
			                   :  $signed({1'b0, rvc_c[SPT_W-2:0]});
			tvd_s4 <= vcneg_s3 ? -$signed({1'b0, rvd_c[SPT_W-2:0]})
			                   :  $signed({1'b0, rvd_c[SPT_W-2:0]});
			pa_s4     <= accm_s3 * sqa_s3;
			pd_s4     <= accm_s3 * sqd_s3;
			accneg_s4 <= accneg_s3;
			ratio_s4  <= ratio_s3;
			start_s4  <= start_s3;
		end
	end

	// ---------------- stage 5: round square terms, sum speed terms ---------
	localparam int SPS_W = 43;

	logic [PROD_W-1:0]        rpa_c, rpd_c;

	logic signed [SQT_W-1:0]  xa_s5, xd_s5;
	logic signed [SPS_W-1:0]  spd_s5;
	logic signed [SPD_W-1:0]  ratio_s5;
	logic signed [POS_W-1:0]  start_s5;

	assign rpa_c = (pa_s4 + (PROD_W'(1) << 8)) >> 9;
	assign rpd_c = (pd_s4 + (PROD_W'(1) << 8)) >> 9;

	always_ff @(posedge clk) begin
		if (adv) begin
			xa_s5 <= accneg_s4 ? -$signed({1'b0, rpa_c[SQT_W-2:0]})
			                   :  $signed({1'b0, rpa_c[SQT_W-2:0]});
			xd_s5 <= accneg_s4 ? -$signed({1'b0, rpd_c[SQT_W-2:0]})
			                   :  $signed({1'b0, rpd_c[SQT_W-2:0]});
			spd_s5 <= SPS_W'(tv0_s4) + SPS_W'(tvc_s4) + SPS_W'(tvd_s4);
			ratio_s5 <= ratio_s4;
			start_s5 <= start_s4;
		end
	end

	// ---------------- stage 6: full distance sum ----------------
	logic signed [SUM_W-1:0]  sum_s6;
	logic signed [SPD_W-1:0]  ratio_s6;
	logic signed [POS_W-1:0]  start_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			// decel square term is subtracted
			sum_s6   <= SUM_W'(spd_s5) + SUM_W'(xa_s5) - SUM_W'(xd_s5);
			ratio_s6 <= ratio_s5;
			start_s6 <= start_s5;
		end
	end

	// ---------------- stage 7: saturate distance ----------------
	logic signed [POS_W-1:0]  dist_s7;
	logic signed [SPD_W-1:0]  ratio_s7;
	logic signed [POS_W-1:0]  start_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s7  <= sat48(sum_s6);
			ratio_s7 <= ratio_s6;
			start_s7 <= start_s6;
		end
	end

	// ---------------- stage 8: magnitudes for the ratio multiply -----------
	localparam int DL_W = 24;
	localparam int DH_W = POS_W - DL_W;

	logic [SPD_W-1:0]         rm_s8;
	logic [POS_W-1:0]         dm_s8;
	logic                     neg_s8;
	logic signed [POS_W-1:0]  dist_s8, start_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			rm_s8    <= ratio_s7[SPD_W-1] ? (~ratio_s7 + 1'b1) : ratio_s7;
			dm_s8    <= dist_s7[POS_W-1] ? (~dist_s7 + 1'b1) : dist_s7;
			neg_s8   <= ratio_s7[SPD_W-1] ^ dist_s7[POS_W-1];
			dist_s8  <= dist_s7;
			start_s8 <= start_s7;
		end
	end

	// ---------------- stage 9: split 32x24 products ----------------
	localparam int QP_W = SPD_W + DL_W;

	logic [QP_W-1:0]          q_s9, pl_s9;
	logic                     neg_s9;
	logic signed [POS_W-1:0]  dist_s9, start_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s9     <= rm_s8 * dm_s8[POS_W-1:DL_W];
			pl_s9    <= rm_s8 * dm_s8[DL_W-1:0];
			neg_s9   <= neg_s8;
			dist_s9  <= dist_s8;
			start_s9 <= start_s8;
		end
	end

	// ---------------- stage 10: align partial products ----------------
	localparam int QH_W  = QP_W - 6;
	localparam int LOW_W = QP_W + 1;

	logic [QH_W-1:0]          qh_s10;
	logic [LOW_W-1:0]         low_s10;
	logic                     neg_s10;
	logic signed [POS_W-1:0]  dist_s10, start_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			qh_s10    <= q_s9[QP_W-1:6];
			low_s10   <= LOW_W'({q_s9[5:0], {DL_W{1'b0}}}) + LOW_W'(pl_s9)
			             + (LOW_W'(1) << 29);
			neg_s10   <= neg_s9;
			dist_s10  <= dist_s9;
			start_s10 <= start_s9;
		end
	end

	// ---------------- stage 11: scaled axis offset ----------------
	localparam int RES_W = QH_W + 1;
	localparam int SCL_W = RES_W + 1;

	logic [RES_W-1:0]         res_c;
	logic signed [SCL_W-1:0]  scaled_s11;
	logic signed [POS_W-1:0]  dist_s11, start_s11;

	assign res_c = RES_W'(qh_s10) + RES_W'(low_s10[LOW_W-1:30]);

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s11 <= neg_s10 ? -$signed({1'b0, res_c}) : $signed({1'b0, res_c});
			dist_s11   <= dist_s10;
			start_s11  <= start_s10;
		end
	end

	// ---------------- stage 12: output register ----------------
	logic signed [POS_W-1:0]  coord_s12, dist_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			coord_s12 <= sat48(SUM_W'(start_s11) + SUM_W'(scaled_s11));
			dist_s12  <= dist_s11;
		end
	end

	assign m_tdata = {dist_s12, coord_s12};

	// ---------------- checks ----------------
	// the three phase parts always add back up to the clamped time
	a_split_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> (split_sum_c == t_s1))
		else $error("phase split does not add up to clamped time");

	// a held pipeline keeps every item in place
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	// an empty output register never blocks input
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NUM_STAGES-1] |-> s_tready)
		else $error("input blocked with empty output register");

endmodule
